/* src/dft_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package dft_pkg;

   // Token kinds carried on the result channel.
   localparam logic [2:0] KIND_NAME     = 3'd0;
   localparam logic [2:0] KIND_DATA     = 3'd1;
   localparam logic [2:0] KIND_CMD_DONE = 3'd2;
   localparam logic [2:0] KIND_VAR_DONE = 3'd3;
   localparam logic [2:0] KIND_FIELD    = 3'd4;
   localparam logic [2:0] KIND_SEP      = 3'd5;
   localparam logic [2:0] KIND_LINE     = 3'd6;

   // Protocol characters.
   localparam logic [7:0] CHAR_AT    = 8'h40;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;

   // Configuration register map (word index).
   localparam int unsigned CSR_ADDR_W = 5;
   localparam logic [2:0] CSR_OWN_ADDRESS   = 3'd0;
   localparam logic [2:0] CSR_END_MARKER    = 3'd1;
   localparam logic [2:0] CSR_COMMAND_CODE  = 3'd2;
   localparam logic [2:0] CSR_VARIABLE_CODE = 3'd3;
   localparam logic [2:0] CSR_FAST_MODE     = 3'd4;

   // One result transfer.
   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] data;
      logic [4:0] position;
      logic [3:0] field;
      logic       is_float;
      logic       truncated;
   } token_type;

endpackage

`default_nettype wire

/* src/debug_frame_tokenizer_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// Byte-serial tokenizer for a small debug protocol. One received byte is taken
// per cycle on the req_ channel while req_stall is low, and each byte yields zero
// or one registered token on the rsp_ channel. In structured mode a frame is
// '@', a type byte, an address byte, a name, and then either the end marker
// (command) or ':' with data and the end marker (variable); frames with an unknown
// type or a foreign address are dropped silently. In fast mode a line "@a,b,c\r"
// is split into field characters, separators and a line end. Names, data and
// fields longer than MAX_CHARS, and lines with more than MAX_FIELDS fields, lose
// the excess characters and report truncated for the rest of the frame or line.
// The whole parse step is a single pass of logic between the input port and the
// result register, so the sustained rate is one byte per clock while rsp_stall is
// low; the result register is backed by one skid entry, so a byte is still accepted
// in the cycle the downstream side first stalls, and req_stall rises only once that
// skid entry is occupied. The user must write the configuration registers over the
// APB-style csr_ port only while the tokenizer is idle; the block does not enforce
// this. Any write to fast_mode returns the parser to waiting for '@'.
module debug_frame_tokenizer_unit #(
   parameter int unsigned MAX_CHARS  = 32,
   parameter int unsigned MAX_FIELDS = 16
) (
   input  wire logic                           clock,
   input  wire logic                           reset,

   input  wire logic                           req_valid,
   output      logic                           req_stall,
   input  wire logic [7:0]                     req_rx_byte,

   output      logic                           rsp_valid,
   input  wire logic                           rsp_stall,
   output      logic [2:0]                     rsp_token_kind,
   output      logic [7:0]                     rsp_token_byte,
   output      logic [4:0]                     rsp_char_position,
   output      logic [3:0]                     rsp_field_number,
   output      logic                           rsp_is_float,
   output      logic                           rsp_truncated,

   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [dft_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]                    csr_pwdata,
   output      logic [31:0]                    csr_prdata,
   output      logic                           csr_pready
);
   import dft_pkg::*;

   // Counters are wide enough to hold their limit itself.
   localparam int unsigned CW = $clog2(MAX_CHARS + 1);
   localparam int unsigned FW = $clog2(MAX_FIELDS + 1);

   typedef enum logic [2:0] {
      PH_HEAD,
      PH_TYPE,
      PH_ADDR,
      PH_NAME,
      PH_DATA,
      PH_FAST
   } phase_type;

   // Configuration registers.
   logic [7:0] own_address_ff;
   logic [7:0] end_marker_ff;
   logic [7:0] command_code_ff;
   logic [7:0] variable_code_ff;
   logic       fast_mode_ff;

   // Parser state.
   phase_type     phase_ff, phase_in;
   logic          is_var_ff, is_var_in;
   logic [CW-1:0] char_count_ff, char_count_in;
   logic [FW-1:0] field_count_ff, field_count_in;
   logic          float_ff, float_in;
   logic          overflow_ff, overflow_in;

   // Result register and its skid entry.
   logic      out_valid_ff;
   token_type out_ff;
   logic      skid_valid_ff;
   token_type skid_ff;

   logic      tok_valid;
   token_type tok;

   logic       req_accept;
   logic       out_free;
   logic       csr_write;
   logic [2:0] csr_index;
   logic [7:0] rx;
   logic       chars_full;
   logic       float_next;
   logic [CW+4:0] pos_wide;
   logic [FW+3:0] field_wide;
   logic [FW-1:0] line_field;
   logic [FW+3:0] line_field_wide;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = skid_valid_ff;
   assign out_free   = !out_valid_ff || !rsp_stall;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[4:2];

   always_comb begin
      case (csr_index)
         CSR_OWN_ADDRESS:   csr_prdata = {24'd0, own_address_ff};
         CSR_END_MARKER:    csr_prdata = {24'd0, end_marker_ff};
         CSR_COMMAND_CODE:  csr_prdata = {24'd0, command_code_ff};
         CSR_VARIABLE_CODE: csr_prdata = {24'd0, variable_code_ff};
         CSR_FAST_MODE:     csr_prdata = {31'd0, fast_mode_ff};
         default:           csr_prdata = 32'd0;
      endcase
   end

   assign rx         = req_rx_byte;
   assign chars_full = char_count_ff >= CW'(MAX_CHARS);
   assign float_next = float_ff || (rx == CHAR_DOT);

   // Positions and field numbers are reported modulo 32 and 16.
   assign pos_wide   = (CW + 5)'(char_count_ff);
   assign field_wide = (FW + 4)'(field_count_ff);

   // A line end never reports a field beyond the last one that exists.
   assign line_field = (field_count_ff >= FW'(MAX_FIELDS - 1)) ?
                       FW'(MAX_FIELDS - 1) : field_count_ff;
   assign line_field_wide = (FW + 4)'(line_field);

   always_comb begin
      phase_in       = phase_ff;
      is_var_in      = is_var_ff;
      char_count_in  = char_count_ff;
      field_count_in = field_count_ff;
      float_in       = float_ff;
      overflow_in    = overflow_ff;

      tok_valid      = 1'b0;
      tok.kind       = KIND_NAME;
      tok.data       = 8'd0;
      tok.position   = 5'd0;
      tok.field      = 4'd0;
      tok.is_float   = 1'b0;
      tok.truncated  = overflow_ff;

      if (req_accept) begin
         if (fast_mode_ff) begin
            if (phase_ff != PH_FAST) begin
               if (rx == CHAR_AT) begin
                  is_var_in      = 1'b0;
                  char_count_in  = '0;
                  field_count_in = '0;
                  float_in       = 1'b0;
                  overflow_in    = 1'b0;
                  phase_in       = PH_FAST;
               end else begin
                  phase_in = PH_HEAD;
               end
            end else if (rx == CHAR_CR) begin
               phase_in  = PH_HEAD;
               tok_valid = 1'b1;
               tok.kind  = KIND_LINE;
               tok.field = line_field_wide[3:0];
            end else if (rx == CHAR_COMMA) begin
               if (field_count_ff >= FW'(MAX_FIELDS - 1)) begin
                  // This separator would open one field too many.
                  field_count_in = FW'(MAX_FIELDS);
                  overflow_in    = 1'b1;
               end else begin
                  field_count_in = field_count_ff + FW'(1);
                  char_count_in  = '0;
                  tok_valid      = 1'b1;
                  tok.kind       = KIND_SEP;
                  tok.field      = field_wide[3:0];
               end
            end else if (field_count_ff >= FW'(MAX_FIELDS)) begin
               overflow_in = 1'b1;
            end else if (chars_full) begin
               overflow_in = 1'b1;
            end else begin
               char_count_in = char_count_ff + CW'(1);
               tok_valid     = 1'b1;
               tok.kind      = KIND_FIELD;
               tok.data      = rx;
               tok.position  = pos_wide[4:0];
               tok.field     = field_wide[3:0];
            end
         end else begin
            case (phase_ff)
               PH_HEAD, PH_FAST: begin
                  // A fast mode phase left over from a mode change acts as idle.
                  phase_in = PH_HEAD;
                  if (rx == CHAR_AT) begin
                     is_var_in      = 1'b0;
                     char_count_in  = '0;
                     field_count_in = '0;
                     float_in       = 1'b0;
                     overflow_in    = 1'b0;
                     phase_in       = PH_TYPE;
                  end
               end
               PH_TYPE: begin
                  // When both codes match, the frame is a command.
                  if (rx == command_code_ff) begin
                     is_var_in = 1'b0;
                     phase_in  = PH_ADDR;
                  end else if (rx == variable_code_ff) begin
                     is_var_in = 1'b1;
                     phase_in  = PH_ADDR;
                  end else begin
                     phase_in = PH_HEAD;
                  end
               end
               PH_ADDR: begin
                  phase_in = (rx == own_address_ff) ? PH_NAME : PH_HEAD;
               end
               PH_NAME: begin
                  if (!is_var_ff && rx == end_marker_ff) begin
                     phase_in  = PH_HEAD;
                     tok_valid = 1'b1;
                     tok.kind  = KIND_CMD_DONE;
                  end else if (rx == CHAR_COLON) begin
                     // A colon is dropped in a command and opens the data otherwise.
                     if (is_var_ff) begin
                        char_count_in = '0;
                        phase_in      = PH_DATA;
                     end
                  end else if (chars_full) begin
                     overflow_in = 1'b1;
                  end else begin
                     char_count_in = char_count_ff + CW'(1);
                     tok_valid     = 1'b1;
                     tok.kind      = KIND_NAME;
                     tok.data      = rx;
                     tok.position  = pos_wide[4:0];
                  end
               end
               PH_DATA: begin
                  if (rx == end_marker_ff) begin
                     phase_in     = PH_HEAD;
                     tok_valid    = 1'b1;
                     tok.kind     = KIND_VAR_DONE;
                     tok.is_float = float_ff;
                  end else if (chars_full) begin
                     overflow_in = 1'b1;
                  end else begin
                     char_count_in = char_count_ff + CW'(1);
                     float_in      = float_next;
                     tok_valid     = 1'b1;
                     tok.kind      = KIND_DATA;
                     tok.data      = rx;
                     tok.position  = pos_wide[4:0];
                     tok.is_float  = float_next;
                  end
               end
               default: begin
                  phase_in = PH_HEAD;
               end
            endcase
         end
      end

      if (csr_write && csr_index == CSR_FAST_MODE) begin
         phase_in = PH_HEAD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_address_ff   <= 8'd0;
         end_marker_ff    <= CHAR_CR;
         command_code_ff  <= 8'd67;
         variable_code_ff <= 8'd86;
         fast_mode_ff     <= 1'b0;
         phase_ff         <= PH_HEAD;
         is_var_ff        <= 1'b0;
         char_count_ff    <= '0;
         field_count_ff   <= '0;
         float_ff         <= 1'b0;
         overflow_ff      <= 1'b0;
         out_valid_ff     <= 1'b0;
         skid_valid_ff    <= 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_OWN_ADDRESS:   own_address_ff   <= csr_pwdata[7:0];
               CSR_END_MARKER:    end_marker_ff    <= csr_pwdata[7:0];
               CSR_COMMAND_CODE:  command_code_ff  <= csr_pwdata[7:0];
               CSR_VARIABLE_CODE: variable_code_ff <= csr_pwdata[7:0];
               CSR_FAST_MODE:     fast_mode_ff     <= csr_pwdata[0];
               default: begin
               end
            endcase
         end

         phase_ff       <= phase_in;
         is_var_ff      <= is_var_in;
         char_count_ff  <= char_count_in;
         field_count_ff <= field_count_in;
         float_ff       <= float_in;
         overflow_ff    <= overflow_in;

         // The skid entry drains first; no byte is taken while it is full.
         if (out_free) begin
            if (skid_valid_ff) begin
               out_valid_ff  <= 1'b1;
               skid_valid_ff <= 1'b0;
            end else begin
               out_valid_ff <= tok_valid;
            end
         end else if (tok_valid) begin
            skid_valid_ff <= 1'b1;
         end
      end

      if (out_free) begin
         out_ff <= skid_valid_ff ? skid_ff : tok;
      end else if (tok_valid) begin
         skid_ff <= tok;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_token_kind    = out_ff.kind;
   assign rsp_token_byte    = out_ff.data;
   assign rsp_char_position = out_ff.position;
   assign rsp_field_number  = out_ff.field;
   assign rsp_is_float      = out_ff.is_float;
   assign rsp_truncated     = out_ff.truncated;

endmodule

`default_nettype wire

/* src/dft_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module dft_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [2:0] rsp_token_kind,
   input wire logic [7:0] rsp_token_byte,
   input wire logic [4:0] rsp_char_position,
   input wire logic       rsp_is_float
);
   import dft_pkg::*;

   // A stalled token must not change before it is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_token_kind) &&
                                $stable(rsp_token_byte))
      else $error("stalled token changed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_token_kind != 3'd7)
      else $error("token kind out of range");

   // Only character tokens carry a byte and a position.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_token_kind == KIND_CMD_DONE || rsp_token_kind == KIND_VAR_DONE ||
                    rsp_token_kind == KIND_SEP || rsp_token_kind == KIND_LINE)
      |-> rsp_token_byte == 8'd0 && rsp_char_position == 5'd0)
      else $error("non-character token carries character data");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_float |->
         (rsp_token_kind == KIND_DATA || rsp_token_kind == KIND_VAR_DONE))
      else $error("float flag on a token outside variable data");

endmodule

bind debug_frame_tokenizer_unit dft_checker u_dft_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_token_kind    (rsp_token_kind),
   .rsp_token_byte    (rsp_token_byte),
   .rsp_char_position (rsp_char_position),
   .rsp_is_float      (rsp_is_float)
);

`default_nettype wire
